>>> hdl/vtpd_pkg.sv
// shared types and constants for the vertex transform with perspective divide
package vtpd_pkg;

  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  localparam int CoefW    = 32;
  localparam int NumRegs  = 8;
  localparam int RegW     = 64;
  localparam int RegIdxW  = 3;
  localparam int ProdW    = CoefW + CoordW;
  localparam int AccW     = ProdW + 2;
  // divider works on |num| << FracBits over |den|
  localparam int DivNumW  = CoordW + FracBits;
  localparam int QuoW     = DivNumW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic [RegW-1:0]          cfg_reg_t;

  // reset value: identity in Q16.16
  localparam logic [RegW-1:0] RstReg [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  // side information that travels with the item through the divider
  typedef struct packed {
    logic sat;
    logic dz;
    logic last;
    logic neg_x;
    logic neg_y;
    logic neg_z;
    coord_t w;
  } side_t;

endpackage

>>> hdl/vtpd_if.sv
// valid/ready stream interfaces for vertex items and results
interface vtpd_in_if;
  import vtpd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;
  coord_t in_w;
  logic   chunk_last;
  modport source (output valid, in_x, in_y, in_z, in_w, chunk_last, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_w, chunk_last, output ready);
endinterface

interface vtpd_out_if;
  import vtpd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  coord_t out_w;
  logic   div_by_zero;
  logic   saturated;
  logic   chunk_last_out;
  modport source (output valid, out_x, out_y, out_z, out_w, div_by_zero, saturated,
                  chunk_last_out, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, div_by_zero, saturated,
                chunk_last_out, output ready);
endinterface

>>> hdl/vtpd_xform.sv
// matrix times vertex: multiply stage, sum stage, shift and clamp stage
module vtpd_xform
  import vtpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  coord_t                 vin [4],
  input  logic                   last_in,
  input  coef_t                  coef [16],
  output logic                   out_vld,
  output coord_t                 clip [4],
  output logic [3:0]             csat,
  output logic                   last_out
);

  // clamp bounds at the width of the shifted sum
  localparam logic signed [AccW-FracBits-1:0] ShMax =
    {{(AccW-FracBits-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
  localparam logic signed [AccW-FracBits-1:0] ShMin =
    {{(AccW-FracBits-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};

  logic signed [ProdW-1:0] prod_r [16];
  logic signed [AccW-1:0]  acc_r [4];
  coord_t                  clip_r [4];
  logic [3:0]              csat_r;
  logic [2:0]              vld_r;
  logic [2:0]              last_r;

  // valid and mark shift with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r <= {last_r[1:0], last_in};
    end
  end

  // sixteen products, coefficient 4*col+row times component col
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 16; i++) begin
        prod_r[i] <= ProdW'(coef[i]) * ProdW'(vin[i/4]);
      end
    end
  end

  // row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        acc_r[r] <= AccW'(prod_r[r]) + AccW'(prod_r[4+r]) +
                    AccW'(prod_r[8+r]) + AccW'(prod_r[12+r]);
      end
    end
  end

  // scale back and clamp to coordinate range
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        logic signed [AccW-FracBits-1:0] sh;
        sh = acc_r[r][AccW-1:FracBits];
        if (sh > ShMax) begin
          clip_r[r] <= {1'b0, {(CoordW-1){1'b1}}};
          csat_r[r] <= 1'b1;
        end else if (sh < ShMin) begin
          clip_r[r] <= {1'b1, {(CoordW-1){1'b0}}};
          csat_r[r] <= 1'b1;
        end else begin
          clip_r[r] <= sh[CoordW-1:0];
          csat_r[r] <= 1'b0;
        end
      end
    end
  end

  assign out_vld  = vld_r[2];
  assign clip     = clip_r;
  assign csat     = csat_r;
  assign last_out = last_r[2];

endmodule

>>> hdl/vtpd_div.sv
// pipelined restoring divider for x, y and z, one quotient bit per stage
module vtpd_div
  import vtpd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  coord_t clip [4],
  input  logic [3:0] csat,
  input  logic   last_in,
  output logic   out_vld,
  output coord_t res [3],
  output side_t  side_out
);

  localparam int Stg = QuoW;
  localparam int RemW = CoordW + 1;

  logic [DivNumW-1:0] num_r [Stg+1][3];
  logic [RemW-1:0]    rem_r [Stg+1][3];
  logic [CoordW:0]    den_r [Stg+1];
  side_t              side_r [Stg+1];
  logic [Stg:0]       vld_r;
  side_t              side_in;
  logic [CoordW:0]    dmag;

  // operand setup: magnitudes and signs, zero divisor check
  always_comb begin
    dmag = clip[3][CoordW-1] ? (CoordW+1)'(-{clip[3][CoordW-1], clip[3]})
                             : (CoordW+1)'(clip[3]);
    side_in.w     = clip[3];
    side_in.dz    = (clip[3] == '0);
    side_in.last  = last_in;
    side_in.sat   = csat[3] | (!side_in.dz & (|csat[2:0]));
    side_in.neg_x = clip[0][CoordW-1] ^ clip[3][CoordW-1];
    side_in.neg_y = clip[1][CoordW-1] ^ clip[3][CoordW-1];
    side_in.neg_z = clip[2][CoordW-1] ^ clip[3][CoordW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Stg-1:0], in_vld};
    end
  end

  // stage 0 loads operands, then each stage resolves one bit
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        logic [CoordW:0] m;
        m = clip[c][CoordW-1] ? (CoordW+1)'(-{clip[c][CoordW-1], clip[c]})
                              : (CoordW+1)'(clip[c]);
        num_r[0][c] <= {m[CoordW-1:0], {FracBits{1'b0}}};
        rem_r[0][c] <= '0;
      end
      den_r[0]  <= dmag;
      side_r[0] <= side_in;
      for (int s = 0; s < Stg; s++) begin
        for (int c = 0; c < 3; c++) begin
          logic [RemW:0] t;
          t = {rem_r[s][c], num_r[s][c][DivNumW-1]};
          if (t >= (RemW+1)'(den_r[s])) begin
            rem_r[s+1][c] <= RemW'(t - (RemW+1)'(den_r[s]));
            num_r[s+1][c] <= {num_r[s][c][DivNumW-2:0], 1'b1};
          end else begin
            rem_r[s+1][c] <= RemW'(t);
            num_r[s+1][c] <= {num_r[s][c][DivNumW-2:0], 1'b0};
          end
        end
        den_r[s+1]  <= den_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  // sign, clamp and zero-divisor handling
  always_comb begin
    side_out = side_r[Stg];
    for (int c = 0; c < 3; c++) begin
      logic [QuoW-1:0] q;
      logic            ng;
      q  = num_r[Stg][c];
      ng = (c == 0) ? side_r[Stg].neg_x : (c == 1) ? side_r[Stg].neg_y
                                                   : side_r[Stg].neg_z;
      if (side_r[Stg].dz) begin
        res[c] = '0;
      end else if (ng) begin
        if (q > QuoW'({1'b1, {(CoordW-1){1'b0}}})) begin
          res[c] = {1'b1, {(CoordW-1){1'b0}}};
          side_out.sat = 1'b1;
        end else begin
          res[c] = CoordW'(-q);
        end
      end else if (q > QuoW'({1'b0, {(CoordW-1){1'b1}}})) begin
        res[c] = {1'b0, {(CoordW-1){1'b1}}};
        side_out.sat = 1'b1;
      end else begin
        res[c] = q[CoordW-1:0];
      end
    end
  end

  assign out_vld = vld_r[Stg];

endmodule

>>> hdl/vertex_transform_perspective_divide.sv
// top level: config registers, transform, divider and output skid register
// pipeline: 3 transform stages, 49 divider stages and 1 output register
// throughput: one item per cycle; the whole pipe advances when the output
// register is free or being taken, so a stall holds every stage in place
// reset: synchronous active-low rst_n clears valid bits and loads the identity matrix
module vertex_transform_perspective_divide
  import vtpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  vtpd_in_if.sink            in_ch,
  vtpd_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [RegIdxW-1:0] cfg_idx,
  input  logic [RegW-1:0]    cfg_wdata
);

  cfg_reg_t   mreg_r [NumRegs];
  coef_t      coef [16];
  logic       en;
  logic       x_vld, d_vld, x_last;
  coord_t     clip [4];
  logic [3:0] csat;
  coord_t     vin [4];
  coord_t     res [3];
  side_t      side;
  logic       ovld_r;
  coord_t     ox_r, oy_r, oz_r;
  side_t      os_r;

  // matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) mreg_r[i] <= RstReg[i];
    end else if (cfg_we) begin
      mreg_r[cfg_idx] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      coef[i] = mreg_r[i/2][(i%2)*CoefW +: CoefW];
    end
    vin[0] = in_ch.in_x;
    vin[1] = in_ch.in_y;
    vin[2] = in_ch.in_z;
    vin[3] = in_ch.in_w;
  end

  // pipe moves when the output slot is empty or being taken
  assign en          = !ovld_r || out_ch.ready;
  assign in_ch.ready = en;

  vtpd_xform u_xform (
    .clk, .rst_n, .en,
    .in_vld  (in_ch.valid),
    .vin,
    .last_in (in_ch.chunk_last),
    .coef,
    .out_vld (x_vld),
    .clip, .csat,
    .last_out(x_last)
  );

  vtpd_div u_div (
    .clk, .rst_n, .en,
    .in_vld  (x_vld),
    .clip, .csat,
    .last_in (x_last),
    .out_vld (d_vld),
    .res,
    .side_out(side)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= res[0];
      oy_r <= res[1];
      oz_r <= res[2];
      os_r <= side;
    end
  end

  assign out_ch.valid          = ovld_r;
  assign out_ch.out_x          = ox_r;
  assign out_ch.out_y          = oy_r;
  assign out_ch.out_z          = oz_r;
  assign out_ch.out_w          = os_r.w;
  assign out_ch.div_by_zero    = os_r.dz;
  assign out_ch.saturated      = os_r.sat;
  assign out_ch.chunk_last_out = os_r.last;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && !out_ch.ready |=> ovld_r && $stable(ox_r) && $stable(os_r))
    else $error("result changed under stall");

  // zero divisor gives zero coordinates
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && os_r.dz |-> ox_r == '0 && oy_r == '0 && oz_r == '0 && os_r.w == '0)
    else $error("zero divisor result wrong");

  // ready follows output slot
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !ovld_r |-> in_ch.ready)
    else $error("input stalled with empty output");

endmodule
